### sv/cbew_pkg.sv
// ----------------------------------------------------------------------------
// cbew_pkg: shared types and constants of the circuit breaker
// Request and response payloads, mode and request codes, register indexes
// and the reset values of the configuration registers.
// ----------------------------------------------------------------------------
package cbew_pkg;

  localparam int unsigned NOW_W       = 48;
  localparam int unsigned SEC_W       = 32;
  localparam int unsigned CNT_W       = 7;
  localparam int unsigned CONSEC_W    = 16;
  localparam int unsigned PROBE_W     = 4;
  localparam int unsigned CFG_W       = 24;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned MS_PER_S    = 1000;
  localparam int unsigned REM_W       = 10;
  localparam int unsigned WINDOW_SLOTS = 64;

  localparam logic [1:0] REQ_ALLOW   = 2'd0;
  localparam logic [1:0] REQ_HW      = 2'd1;
  localparam logic [1:0] REQ_PROTO   = 2'd2;
  localparam logic [1:0] REQ_SUCCESS = 2'd3;

  localparam logic [1:0] MODE_CLOSED = 2'd0;
  localparam logic [1:0] MODE_OPEN   = 2'd1;
  localparam logic [1:0] MODE_HALF   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HW_THR      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROTO_THR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CONSEC_LIM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_LIM   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_NEED  = 3'd6;

  localparam logic [23:0] RST_COOLDOWN   = 24'd30000;
  localparam logic [15:0] RST_WINDOW     = 16'd60;
  localparam logic [6:0]  RST_HW_THR     = 7'd10;
  localparam logic [6:0]  RST_PROTO_THR  = 7'd50;
  localparam logic [15:0] RST_CONSEC_LIM = 16'd10;
  localparam logic [3:0]  RST_PROBE_LIM  = 4'd3;
  localparam logic [3:0]  RST_PROBE_NEED = 4'd3;
  localparam logic [3:0]  PASS_MAX       = 4'd15;
  localparam logic [15:0] CONSEC_MAX     = 16'hFFFF;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [NOW_W-1:0] now_ms;
  } req_t;

  typedef struct packed {
    logic                allowed;
    logic [1:0]          breaker_mode;
    logic [CONSEC_W-1:0] consec_errors;
    logic [CNT_W-1:0]    hw_window_count;
    logic [CNT_W-1:0]    proto_window_count;
  } rsp_t;

endpackage

### sv/cbew_ram.sv
// ----------------------------------------------------------------------------
// cbew_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cbew_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### sv/cbew_div.sv
// ----------------------------------------------------------------------------
// cbew_div: conversion of milliseconds to seconds by reciprocal multiplication
// The timestamp is shifted right by three and multiplied by the rounded-up
// reciprocal of 125, one 16-bit digit of it per cycle; the low bits of the
// quotient are the second count.
// ----------------------------------------------------------------------------
module cbew_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [cbew_pkg::NOW_W-1:0]      dividend_i,
  output logic                            done_o,
  output logic [cbew_pkg::SEC_W-1:0]      quot_o
);

  localparam int unsigned XW    = cbew_pkg::NOW_W - 3;
  localparam int unsigned DW    = 16;
  localparam int unsigned ND    = 3;
  localparam int unsigned PW    = XW + DW;
  localparam int unsigned AW    = XW + DW * ND;
  localparam int unsigned SHIFT = 52;
  localparam int unsigned CW    = 2;
  // Rounded-up 2^52 / 125, exact for every 45-bit dividend.
  localparam logic [DW*ND-1:0] RECIP = 48'd36028797018964;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [XW-1:0] x_q, x_d;
  logic [AW-1:0] acc_q, acc_d;
  logic [DW-1:0] digit;
  logic [PW-1:0] prod;

  always_comb begin
    case (cnt_q)
      CW'(2):  digit = RECIP[2*DW +: DW];
      CW'(1):  digit = RECIP[DW +: DW];
      default: digit = RECIP[0 +: DW];
    endcase
  end

  assign prod = PW'(x_q) * PW'(digit);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    x_d    = x_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(ND - 1);
      x_d    = dividend_i[cbew_pkg::NOW_W-1:3];
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = {acc_q[AW-DW-1:0], {DW{1'b0}}} + AW'(prod);
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign quot_o = acc_q[SHIFT +: cbew_pkg::SEC_W];

endmodule

### sv/circuit_breaker_error_window.sv
// Flow: an allow query or a success goes from acceptance straight to the finish state,
// which registers the result once the output is free; the next request is taken after
// that. An error first converts ms to seconds by reciprocal multiplication; then, unless
// the window is empty, it checks C ring entries (1 to WINDOW_SLOTS) from the oldest, one
// ring entry per cycle through the RAM read port, before the write and finish states.
// One request is in work at a time. Reset clears mode, counters, pointers and fills.
// ----------------------------------------------------------------------------
// circuit_breaker_error_window: three-state circuit breaker
// Closed, open and half-open modes driven by timestamped requests, with two
// sliding windows of error timestamps kept in RAM and expired on each error.
// ----------------------------------------------------------------------------
module circuit_breaker_error_window #(
  parameter int unsigned WINDOW_SLOTS = cbew_pkg::WINDOW_SLOTS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  cbew_pkg::req_t                     in_req_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output cbew_pkg::rsp_t                     out_rsp_o,
  input  logic                               cfg_we_i,
  input  logic [cbew_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [cbew_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int unsigned AW = $clog2(WINDOW_SLOTS);
  localparam int unsigned FW = $clog2(WINDOW_SLOTS + 1);
  localparam int unsigned EW = $clog2(2 * WINDOW_SLOTS);
  localparam int unsigned SW = cbew_pkg::SEC_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DIV    = 3'd1;
  localparam logic [2:0] ST_EXP_RD = 3'd2;
  localparam logic [2:0] ST_EXP_CK = 3'd3;
  localparam logic [2:0] ST_WR     = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;

  // Configuration registers.
  logic [23:0] cooldown_q;
  logic [15:0] window_q;
  logic [6:0]  hw_thr_q;
  logic [6:0]  proto_thr_q;
  logic [15:0] consec_lim_q;
  logic [3:0]  probe_lim_q;
  logic [3:0]  probe_need_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cooldown_q   <= cbew_pkg::RST_COOLDOWN;
      window_q     <= cbew_pkg::RST_WINDOW;
      hw_thr_q     <= cbew_pkg::RST_HW_THR;
      proto_thr_q  <= cbew_pkg::RST_PROTO_THR;
      consec_lim_q <= cbew_pkg::RST_CONSEC_LIM;
      probe_lim_q  <= cbew_pkg::RST_PROBE_LIM;
      probe_need_q <= cbew_pkg::RST_PROBE_NEED;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cbew_pkg::CFG_COOLDOWN:   cooldown_q   <= cfg_data_i[23:0];
        cbew_pkg::CFG_WINDOW:     window_q     <= cfg_data_i[15:0];
        cbew_pkg::CFG_HW_THR:     hw_thr_q     <= cfg_data_i[6:0];
        cbew_pkg::CFG_PROTO_THR:  proto_thr_q  <= cfg_data_i[6:0];
        cbew_pkg::CFG_CONSEC_LIM: consec_lim_q <= cfg_data_i[15:0];
        cbew_pkg::CFG_PROBE_LIM:  probe_lim_q  <= cfg_data_i[3:0];
        cbew_pkg::CFG_PROBE_NEED: probe_need_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Control and breaker state.
  logic [2:0]                    state_q, state_d;
  logic [1:0]                    mode_q, mode_d;
  logic [cbew_pkg::NOW_W-1:0]    open_time_q, open_time_d;
  logic [3:0]                    probes_q, probes_d;
  logic [3:0]                    passes_q, passes_d;
  logic [15:0]                   consec_q, consec_d;
  logic [AW-1:0]                 hw_head_q, hw_head_d, pr_head_q, pr_head_d;
  logic [FW-1:0]                 hw_fill_q, hw_fill_d, pr_fill_q, pr_fill_d;
  logic [FW-1:0]                 wfill_q, wfill_d;
  logic [AW-1:0]                 ptr_q, ptr_d;
  logic                          out_valid_q, out_valid_d;

  // Payload registers.
  logic [1:0]                    kind_q;
  logic [cbew_pkg::NOW_W-1:0]    now_q;
  logic [SW-1:0]                 now_s_q, now_s_d;
  cbew_pkg::rsp_t                rsp_q, rsp_d;

  logic                          in_fire;
  logic                          fin_fire;
  logic                          is_hw;
  logic [AW-1:0]                 cur_head, head_next;
  logic [FW-1:0]                 cur_fill;
  logic [EW-1:0]                 old_sum;
  logic [AW-1:0]                 old_addr, ptr_next;
  logic                          ram_re, hw_re, pr_re, hw_we, pr_we;
  logic [AW-1:0]                 raddr;
  logic [SW-1:0]                 hw_rdata, pr_rdata, rdata;
  logic [SW-1:0]                 age;
  logic                          div_start, div_done;
  logic [SW-1:0]                 div_quot;
  logic [15:0]                   consec_inc;
  logic [3:0]                    passes_inc;
  logic                          cool_done;
  logic                          trip;

  assign in_fire   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign div_start = in_fire && ((in_req_i.req_type == cbew_pkg::REQ_HW) ||
                                 (in_req_i.req_type == cbew_pkg::REQ_PROTO));
  assign fin_fire  = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);

  assign is_hw    = (kind_q == cbew_pkg::REQ_HW);
  assign cur_head = is_hw ? hw_head_q : pr_head_q;
  assign cur_fill = is_hw ? hw_fill_q : pr_fill_q;

  // Oldest live entry sits fill slots behind the head.
  assign old_sum  = EW'(cur_head) + EW'(WINDOW_SLOTS) - EW'(wfill_q);
  assign old_addr = (old_sum >= EW'(WINDOW_SLOTS)) ?
                    AW'(old_sum - EW'(WINDOW_SLOTS)) : AW'(old_sum);
  assign ptr_next  = (ptr_q == AW'(WINDOW_SLOTS - 1)) ? '0 : ptr_q + AW'(1);
  assign head_next = (cur_head == AW'(WINDOW_SLOTS - 1)) ? '0 : cur_head + AW'(1);

  assign rdata = is_hw ? hw_rdata : pr_rdata;
  assign age   = now_s_q - rdata;

  assign consec_inc = (consec_q != cbew_pkg::CONSEC_MAX) ? consec_q + 16'd1 : consec_q;
  assign passes_inc = (passes_q < cbew_pkg::PASS_MAX) ? passes_q + 4'd1 : passes_q;
  assign cool_done  = (now_q >= open_time_q) &&
                      ((now_q - open_time_q) >= cbew_pkg::NOW_W'(cooldown_q));

  always_comb begin
    ram_re = 1'b0;
    raddr  = old_addr;
    hw_we  = 1'b0;
    pr_we  = 1'b0;
    if (state_q == ST_EXP_RD) begin
      ram_re = 1'b1;
    end else if (state_q == ST_EXP_CK) begin
      ram_re = 1'b1;
      raddr  = ptr_next;
    end else if (state_q == ST_WR) begin
      hw_we = is_hw;
      pr_we = !is_hw;
    end
  end

  assign hw_re = ram_re && is_hw;
  assign pr_re = ram_re && !is_hw;

  always_comb begin
    trip = 1'b0;
    case (kind_q)
      cbew_pkg::REQ_HW:
        trip = (mode_q == cbew_pkg::MODE_HALF) ||
               (32'(hw_fill_q) >= 32'(hw_thr_q)) || (consec_inc >= consec_lim_q);
      cbew_pkg::REQ_PROTO:
        trip = (32'(pr_fill_q) >= 32'(proto_thr_q)) || (consec_inc >= consec_lim_q);
      default: trip = 1'b0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    open_time_d = open_time_q;
    probes_d    = probes_q;
    passes_d    = passes_q;
    consec_d    = consec_q;
    hw_head_d   = hw_head_q;
    hw_fill_d   = hw_fill_q;
    pr_head_d   = pr_head_q;
    pr_fill_d   = pr_fill_q;
    wfill_d     = wfill_q;
    ptr_d       = ptr_q;
    now_s_d     = now_s_q;
    rsp_d       = rsp_q;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = div_start ? ST_DIV : ST_FIN;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          now_s_d = div_quot;
          wfill_d = cur_fill;
          state_d = (cur_fill == '0) ? ST_WR : ST_EXP_RD;
        end
      end
      ST_EXP_RD: begin
        ptr_d   = old_addr;
        state_d = ST_EXP_CK;
      end
      ST_EXP_CK: begin
        if (age > SW'(window_q)) begin
          wfill_d = wfill_q - FW'(1);
          ptr_d   = ptr_next;
          if (wfill_q == FW'(1)) begin
            state_d = ST_WR;
          end
        end else begin
          state_d = ST_WR;
        end
      end
      ST_WR: begin
        if (is_hw) begin
          hw_head_d = head_next;
          hw_fill_d = (wfill_q < FW'(WINDOW_SLOTS)) ? wfill_q + FW'(1) : wfill_q;
        end else begin
          pr_head_d = head_next;
          pr_fill_d = (wfill_q < FW'(WINDOW_SLOTS)) ? wfill_q + FW'(1) : wfill_q;
        end
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (fin_fire) begin
          rsp_d.allowed = 1'b0;
          case (kind_q)
            cbew_pkg::REQ_ALLOW: begin
              if (mode_q == cbew_pkg::MODE_CLOSED) begin
                rsp_d.allowed = 1'b1;
              end else if (mode_q == cbew_pkg::MODE_OPEN) begin
                if (cool_done) begin
                  probes_d      = '0;
                  passes_d      = '0;
                  mode_d        = cbew_pkg::MODE_HALF;
                  rsp_d.allowed = 1'b1;
                end
              end else if (probes_q < probe_lim_q) begin
                probes_d      = probes_q + 4'd1;
                rsp_d.allowed = 1'b1;
              end
            end
            cbew_pkg::REQ_HW, cbew_pkg::REQ_PROTO: begin
              consec_d = consec_inc;
              if (trip) begin
                if (mode_q != cbew_pkg::MODE_OPEN) begin
                  open_time_d = now_q;
                end
                mode_d = cbew_pkg::MODE_OPEN;
              end
            end
            default: begin
              consec_d = '0;
              if (mode_q == cbew_pkg::MODE_HALF) begin
                passes_d = passes_inc;
                if (passes_inc >= probe_need_q) begin
                  mode_d = cbew_pkg::MODE_CLOSED;
                end
              end
            end
          endcase
          rsp_d.breaker_mode       = mode_d;
          rsp_d.consec_errors      = consec_d;
          rsp_d.hw_window_count    = cbew_pkg::CNT_W'(hw_fill_q);
          rsp_d.proto_window_count = cbew_pkg::CNT_W'(pr_fill_q);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= cbew_pkg::MODE_CLOSED;
      open_time_q <= '0;
      probes_q    <= '0;
      passes_q    <= '0;
      consec_q    <= '0;
      hw_head_q   <= '0;
      hw_fill_q   <= '0;
      pr_head_q   <= '0;
      pr_fill_q   <= '0;
      wfill_q     <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      open_time_q <= open_time_d;
      probes_q    <= probes_d;
      passes_q    <= passes_d;
      consec_q    <= consec_d;
      hw_head_q   <= hw_head_d;
      hw_fill_q   <= hw_fill_d;
      pr_head_q   <= pr_head_d;
      pr_fill_q   <= pr_fill_d;
      wfill_q     <= wfill_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q <= in_req_i.req_type;
      now_q  <= in_req_i.now_ms;
    end
    now_s_q <= now_s_d;
    rsp_q   <= rsp_d;
  end

  cbew_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_req_i.now_ms),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  cbew_ram #(
    .WIDTH (SW),
    .DEPTH (WINDOW_SLOTS)
  ) u_hw_ram (
    .clk_i   (clk_i),
    .we_i    (hw_we),
    .waddr_i (cur_head),
    .wdata_i (now_s_q),
    .re_i    (hw_re),
    .raddr_i (raddr),
    .rdata_o (hw_rdata)
  );

  cbew_ram #(
    .WIDTH (SW),
    .DEPTH (WINDOW_SLOTS)
  ) u_pr_ram (
    .clk_i   (clk_i),
    .we_i    (pr_we),
    .waddr_i (cur_head),
    .wdata_i (now_s_q),
    .re_i    (pr_re),
    .raddr_i (raddr),
    .rdata_o (pr_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  // The window fills never pass the ring size.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hw_fill_q <= FW'(WINDOW_SLOTS)) && (pr_fill_q <= FW'(WINDOW_SLOTS)))
    else $error("window fill exceeds ring size");

  // The divider only finishes while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the division state");

  // A finished request always leaves a pending result behind.
  a_fin_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_fire |=> (out_valid_q && (state_q == ST_IDLE)))
    else $error("result not queued after completion");

  // The breaker mode never takes the unused code.
  a_mode_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q != 2'd3)
    else $error("illegal breaker mode");

endmodule
